// ===== rtl/core/qlsf_pkg.sv =====
// Shared types, constants and small lookup functions for the quadratic lane fit.
// Used by qlsf_ctrl, qlsf_dp and quadratic_least_squares_fit; depends on nothing.
package qlsf_pkg;

  localparam int XW     = 12;   // input coordinate width
  localparam int EW     = 53;   // matrix entry width (widest power sum)
  localparam int TW     = 106;  // product of two entries
  localparam int PW     = 164;  // triple products and determinants
  localparam int DAW    = 162;  // determinant magnitude
  localparam int NW     = 198;  // scaled and rounded numerator
  localparam int RW     = 166;  // division remainder
  localparam int QW     = 33;   // quotient bits kept
  localparam int CXW    = 44;   // CORDIC x and y
  localparam int ZW     = 33;   // CORDIC angle
  localparam int CORDIC_STEPS = 30;
  localparam int PUW    = 9;    // points_used width
  localparam int IN_DW  = 24;
  localparam int OUT_DW = 160;

  localparam logic [2:0] ST_OK   = 3'd0;
  localparam logic [2:0] ST_FEW  = 3'd1;
  localparam logic [2:0] ST_SING = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_DROP = 3'd4;

  // matrix entry selectors; entry (r, c) of the base matrix is code r + c
  localparam logic [2:0] ENT_S4  = 3'd0;
  localparam logic [2:0] ENT_S3  = 3'd1;
  localparam logic [2:0] ENT_S2  = 3'd2;
  localparam logic [2:0] ENT_S1  = 3'd3;
  localparam logic [2:0] ENT_N   = 3'd4;
  localparam logic [2:0] ENT_XY2 = 3'd5;
  localparam logic [2:0] ENT_XY  = 3'd6;
  localparam logic [2:0] ENT_X   = 3'd7;

  localparam logic [1:0] COL_NONE = 2'd3;
  localparam logic [1:0] COL_LAST = 2'd2;
  localparam logic [2:0] TERM_LAST = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ACC_Y2, OP_ACC_Y3, OP_ACC_Y4, OP_ACC_XY, OP_ACC_XY2,
    OP_DET_CLR, OP_MUL_START, OP_MUL_TMP, OP_MUL_ACC, OP_DET_KEEP,
    OP_DIV_START, OP_DIV_END, OP_COR_START, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {EMIT_FEW, EMIT_SING, EMIT_FIT} emit_kind_t;

  typedef enum logic [3:0] {
    S_IDLE, S_Y2, S_Y3, S_Y4, S_XY, S_XY2, S_CHECK, S_MUL1, S_WAIT1, S_MUL2,
    S_WAIT2, S_DET_END, S_DIV, S_COR_START, S_COR_WAIT, S_EMIT
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] sel_a;
    logic [2:0] sel_b;
    logic       from_tmp;
    logic       sub;
    logic [1:0] col;
    emit_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic few;
    logic mul_busy;
    logic div_busy;
    logic cor_busy;
    logic det_zero;
    logic out_free;
  } dp_stat_t;

  // column permutations of the six determinant terms, {row2, row1, row0}
  function automatic logic [1:0] perm_col(input logic [2:0] term, input logic [1:0] row);
    logic [5:0] p;
    case (term)
      3'd0:    p = 6'b10_01_00;
      3'd1:    p = 6'b01_10_00;
      3'd2:    p = 6'b10_00_01;
      3'd3:    p = 6'b00_10_01;
      3'd4:    p = 6'b01_00_10;
      default: p = 6'b00_01_10;
    endcase
    return p[{row, 1'b0} +: 2];
  endfunction

  function automatic logic term_neg(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

  function automatic logic [2:0] entry_code(input logic [1:0] col, input logic [1:0] row,
                                            input logic [1:0] c);
    if (c == col) begin
      return ENT_XY2 + {1'b0, row};
    end
    return {1'b0, row} + {1'b0, c};
  endfunction

  function automatic logic [5:0] div_shift(input logic [1:0] col);
    case (col)
      2'd0:    return 6'd32;
      2'd1:    return 6'd24;
      default: return 6'd14;
    endcase
  endfunction

  function automatic logic [30:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:  return 31'd843314857;
      5'd1:  return 31'd497837829;
      5'd2:  return 31'd263043836;
      5'd3:  return 31'd133525158;
      5'd4:  return 31'd67021686;
      5'd5:  return 31'd33543515;
      5'd6:  return 31'd16775850;
      5'd7:  return 31'd8388437;
      5'd8:  return 31'd4194282;
      5'd9:  return 31'd2097149;
      5'd10: return 31'd1048575;
      5'd11: return 31'd524287;
      5'd12: return 31'd262143;
      5'd13: return 31'd131071;
      5'd14: return 31'd65535;
      5'd15: return 31'd32767;
      5'd16: return 31'd16383;
      5'd17: return 31'd8191;
      5'd18: return 31'd4095;
      5'd19: return 31'd2047;
      5'd20: return 31'd1023;
      5'd21: return 31'd511;
      5'd22: return 31'd255;
      5'd23: return 31'd127;
      5'd24: return 31'd63;
      5'd25: return 31'd31;
      5'd26: return 31'd15;
      5'd27: return 31'd8;
      5'd28: return 31'd4;
      5'd29: return 31'd2;
      default: return 31'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/qlsf_ctrl.sv =====
// Sequencer for the lane fit: power sum updates, determinant terms, divisions, CORDIC.
// Depends on qlsf_pkg; drives qlsf_dp through dp_cmd_t and reads dp_stat_t.
module qlsf_ctrl
  import qlsf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_tlast,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic       last_r, last_nxt;
  logic [1:0] col_r, col_nxt;
  logic [2:0] term_r, term_nxt;
  emit_kind_t kind_r, kind_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      col_r   <= COL_NONE;
      term_r  <= '0;
      kind_r  <= EMIT_FEW;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      col_r   <= col_nxt;
      term_r  <= term_nxt;
      kind_r  <= kind_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    col_nxt      = col_r;
    term_nxt     = term_r;
    kind_nxt     = kind_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.kind     = kind_r;
    cmd.col      = col_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op   = OP_LOAD;
          last_nxt = in_tlast;
          if (stat.keep) begin
            state_nxt = S_Y2;
          end else if (in_tlast) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_Y2: begin
        cmd.op    = OP_ACC_Y2;
        state_nxt = S_Y3;
      end
      S_Y3: begin
        cmd.op    = OP_ACC_Y3;
        state_nxt = S_Y4;
      end
      S_Y4: begin
        cmd.op    = OP_ACC_Y4;
        state_nxt = S_XY;
      end
      S_XY: begin
        cmd.op    = OP_ACC_XY;
        state_nxt = S_XY2;
      end
      S_XY2: begin
        cmd.op    = OP_ACC_XY2;
        state_nxt = last_r ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (stat.few) begin
          kind_nxt  = EMIT_FEW;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_DET_CLR;
          col_nxt   = COL_NONE;
          term_nxt  = '0;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.op    = OP_MUL_START;
        cmd.sel_a = entry_code(col_r, 2'd0, perm_col(term_r, 2'd0));
        cmd.sel_b = entry_code(col_r, 2'd1, perm_col(term_r, 2'd1));
        state_nxt = S_WAIT1;
      end
      S_WAIT1: begin
        if (!stat.mul_busy) begin
          cmd.op    = OP_MUL_TMP;
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: begin
        cmd.op       = OP_MUL_START;
        cmd.from_tmp = 1'b1;
        cmd.sel_b    = entry_code(col_r, 2'd2, perm_col(term_r, 2'd2));
        state_nxt    = S_WAIT2;
      end
      S_WAIT2: begin
        if (!stat.mul_busy) begin
          cmd.op  = OP_MUL_ACC;
          cmd.sub = term_neg(term_r);
          if (term_r == TERM_LAST) begin
            state_nxt = S_DET_END;
          end else begin
            term_nxt  = term_r + 3'd1;
            state_nxt = S_MUL1;
          end
        end
      end
      S_DET_END: begin
        if (col_r == COL_NONE) begin
          if (stat.det_zero) begin
            kind_nxt  = EMIT_SING;
            state_nxt = S_EMIT;
          end else begin
            cmd.op    = OP_DET_KEEP;
            col_nxt   = 2'd0;
            term_nxt  = '0;
            state_nxt = S_MUL1;
          end
        end else begin
          cmd.op    = OP_DIV_START;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          cmd.op = OP_DIV_END;
          if (col_r == COL_LAST) begin
            state_nxt = S_COR_START;
          end else begin
            col_nxt   = col_r + 2'd1;
            term_nxt  = '0;
            state_nxt = S_MUL1;
          end
        end
      end
      S_COR_START: begin
        cmd.op    = OP_COR_START;
        state_nxt = S_COR_WAIT;
      end
      S_COR_WAIT: begin
        if (!stat.cor_busy) begin
          kind_nxt  = EMIT_FIT;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/qlsf_dp.sv =====
// Datapath of the lane fit: power sums, serial multiplier, divider, CORDIC, result item.
// Depends on qlsf_pkg; commanded by qlsf_ctrl.
module qlsf_dp
  import qlsf_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  output dp_stat_t             stat,
  input  logic                 out_tready,
  output logic                 out_tvalid,
  output logic [OUT_DW-1:0]    out_tdata
);

  localparam int CNT_W = $clog2(MAX_POINTS + 2);
  localparam int DCW   = $clog2(NW);

  logic [CNT_W-1:0]     cnt_r;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [23:0]   y2_r;
  logic signed [20:0]   sy_r, sx_r;
  logic signed [30:0]   sy2_r;
  logic signed [41:0]   sy3_r, sxy2_r;
  logic signed [52:0]   sy4_r;
  logic signed [31:0]   sxy_r;

  logic signed [24:0]   sma, smb;
  logic signed [49:0]   sprod;
  logic                 keep, dropped;
  logic [PUW-1:0]       nval;

  logic signed [EW-1:0] ea, eb;
  logic signed [PW-1:0] ma_r, macc_r, mres;
  logic [EW-1:0]        mb_r;
  logic                 mneg_r, mbusy_r;
  logic signed [TW-1:0] tmp_r;
  logic signed [PW-1:0] det_r;
  logic [DAW-1:0]       ad_r, det_abs;
  logic                 dneg_r;

  logic [NW-1:0]        nsh_r, nv;
  logic [RW-1:0]        rem_r, rsh, dv;
  logic [QW-1:0]        q_r, lim, dmag;
  logic                 wide_r, nneg_r, dbusy_r, dsgn, dsat, ge;
  logic [DCW-1:0]       dcnt_r;
  logic [1:0]           dcol_r;
  logic [31:0]          cval;
  logic signed [31:0]   c0_r, c1_r, c2_r;
  logic                 sat_r;

  logic signed [CXW-1:0] cx_r, cy_r, xs, ys;
  logic signed [ZW-1:0]  cz_r, at, zr, zs;
  logic [4:0]            ci_r;
  logic                  cbusy_r, ypos;

  logic                  ov_r;
  logic [2:0]            os_r;
  logic [31:0]           oc0_r, oc1_r, oc2_r, octe_r;
  logic [17:0]           oyaw_r;
  logic [PUW-1:0]        opu_r;

  assign keep    = cnt_r < CNT_W'(MAX_POINTS);
  assign dropped = cnt_r > CNT_W'(MAX_POINTS);
  assign nval    = dropped ? PUW'(MAX_POINTS) : PUW'(cnt_r);

  function automatic logic signed [EW-1:0] entry_val(input logic [2:0] s);
    case (s)
      ENT_S4:  return sy4_r;
      ENT_S3:  return EW'(sy3_r);
      ENT_S2:  return EW'(sy2_r);
      ENT_S1:  return EW'(sy_r);
      ENT_N:   return EW'(nval);
      ENT_XY2: return EW'(sxy2_r);
      ENT_XY:  return EW'(sxy_r);
      default: return EW'(sx_r);
    endcase
  endfunction

  assign ea = entry_val(cmd.sel_a);
  assign eb = entry_val(cmd.sel_b);

  // power sum products, one per cycle
  always_comb begin
    sma = '0;
    smb = '0;
    case (cmd.op)
      OP_ACC_Y2: begin
        sma = 25'(y_r);
        smb = 25'(y_r);
      end
      OP_ACC_Y3: begin
        sma = 25'(y2_r);
        smb = 25'(y_r);
      end
      OP_ACC_Y4: begin
        sma = 25'(y2_r);
        smb = 25'(y2_r);
      end
      OP_ACC_XY: begin
        sma = 25'(x_r);
        smb = 25'(y_r);
      end
      OP_ACC_XY2: begin
        sma = 25'(x_r);
        smb = 25'(y2_r);
      end
      default: begin
        sma = '0;
      end
    endcase
    sprod = sma * smb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sy_r   <= '0;
      sy2_r  <= '0;
      sy3_r  <= '0;
      sy4_r  <= '0;
      sx_r   <= '0;
      sxy_r  <= '0;
      sxy2_r <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (keep) begin
            x_r   <= in_x;
            y_r   <= in_y;
            cnt_r <= cnt_r + CNT_W'(1);
          end else begin
            cnt_r <= CNT_W'(MAX_POINTS + 1);
          end
        end
        OP_ACC_Y2: begin
          y2_r  <= 24'(sprod);
          sy2_r <= sy2_r + 31'(sprod);
          sy_r  <= sy_r + 21'(y_r);
          sx_r  <= sx_r + 21'(x_r);
        end
        OP_ACC_Y3:  sy3_r  <= sy3_r + 42'(sprod);
        OP_ACC_Y4:  sy4_r  <= sy4_r + 53'(sprod);
        OP_ACC_XY:  sxy_r  <= sxy_r + 32'(sprod);
        OP_ACC_XY2: sxy2_r <= sxy2_r + 42'(sprod);
        OP_EMIT: begin
          cnt_r  <= '0;
          sy_r   <= '0;
          sy2_r  <= '0;
          sy3_r  <= '0;
          sy4_r  <= '0;
          sx_r   <= '0;
          sxy_r  <= '0;
          sxy2_r <= '0;
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase
    end
  end

  // shift-add multiplier, one bit of the magnitude of b per cycle
  assign mres = mneg_r ? -macc_r : macc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.op == OP_MUL_START) begin
      ma_r    <= cmd.from_tmp ? PW'(tmp_r) : PW'(ea);
      mb_r    <= eb[EW-1] ? EW'(-eb) : EW'(eb);
      mneg_r  <= eb[EW-1];
      macc_r  <= '0;
      mbusy_r <= 1'b1;
    end else if (mbusy_r) begin
      if (mb_r == '0) begin
        mbusy_r <= 1'b0;
      end else begin
        if (mb_r[0]) begin
          macc_r <= macc_r + ma_r;
        end
        ma_r <= ma_r << 1;
        mb_r <= mb_r >> 1;
      end
    end
  end

  assign det_abs = det_r[PW-1] ? DAW'(-det_r) : DAW'(det_r);

  // restoring division of |n| * 2^(s+1) + |d| by 2|d|, with s = div_shift(col)
  assign nv  = (NW'(det_abs) << ({1'b0, div_shift(cmd.col)} + 7'd1)) + NW'(ad_r);
  assign rsh = {rem_r[RW-2:0], nsh_r[NW-1]};
  assign dv  = RW'({ad_r, 1'b0});
  assign ge  = rsh >= dv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.op == OP_DIV_START) begin
      nsh_r   <= nv;
      nneg_r  <= det_r[PW-1];
      dcol_r  <= cmd.col;
      rem_r   <= '0;
      q_r     <= '0;
      wide_r  <= 1'b0;
      dcnt_r  <= DCW'(NW - 1);
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      rem_r  <= ge ? rsh - dv : rsh;
      nsh_r  <= nsh_r << 1;
      q_r    <= {q_r[QW-2:0], ge};
      wide_r <= wide_r | q_r[QW-1];
      if (dcnt_r == '0) begin
        dbusy_r <= 1'b0;
      end else begin
        dcnt_r <= dcnt_r - DCW'(1);
      end
    end
  end

  assign dsgn = nneg_r ^ dneg_r;
  assign lim  = dsgn ? QW'(33'h080000000) : QW'(33'h07fffffff);
  assign dsat = wide_r | (q_r > lim);
  assign dmag = dsat ? lim : q_r;
  assign cval = dsgn ? 32'(-dmag) : 32'(dmag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_DET_CLR: begin
          det_r <= '0;
          sat_r <= 1'b0;
        end
        OP_MUL_TMP: tmp_r <= TW'(mres);
        OP_MUL_ACC: det_r <= cmd.sub ? det_r - mres : det_r + mres;
        OP_DET_KEEP: begin
          ad_r   <= det_abs;
          dneg_r <= det_r[PW-1];
          det_r  <= '0;
        end
        OP_DIV_END: begin
          det_r <= '0;
          sat_r <= sat_r | dsat;
          case (dcol_r)
            2'd0:    c0_r <= cval;
            2'd1:    c1_r <= cval;
            default: c2_r <= cval;
          endcase
        end
        default: begin
          sat_r <= sat_r;
        end
      endcase
    end
  end

  // CORDIC vectoring on (1, c1)
  assign xs   = cx_r >>> ci_r;
  assign ys   = cy_r >>> ci_r;
  assign at   = ZW'(atan_entry(ci_r));
  assign ypos = !cy_r[CXW-1] && (cy_r != '0);
  assign zr   = cz_r + ZW'(8192);
  assign zs   = zr >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cbusy_r <= 1'b0;
    end else if (cmd.op == OP_COR_START) begin
      cx_r    <= CXW'(64'sd4294967296);
      cy_r    <= CXW'(c1_r) <<< 8;
      cz_r    <= '0;
      ci_r    <= '0;
      cbusy_r <= 1'b1;
    end else if (cbusy_r) begin
      if (ypos) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
      if (ci_r == 5'(CORDIC_STEPS - 1)) begin
        cbusy_r <= 1'b0;
      end else begin
        ci_r <= ci_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      ov_r  <= 1'b1;
      opu_r <= nval;
      if (cmd.kind == EMIT_FIT) begin
        os_r   <= sat_r ? ST_SAT : (dropped ? ST_DROP : ST_OK);
        oc0_r  <= c0_r;
        oc1_r  <= c1_r;
        oc2_r  <= c2_r;
        octe_r <= (c2_r == 32'sh80000000) ? 32'h7fffffff : 32'(-c2_r);
        oyaw_r <= 18'(-zs);
      end else begin
        os_r   <= (cmd.kind == EMIT_FEW) ? ST_FEW : ST_SING;
        oc0_r  <= '0;
        oc1_r  <= '0;
        oc2_r  <= '0;
        octe_r <= '0;
        oyaw_r <= '0;
      end
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, opu_r, oyaw_r, octe_r, oc2_r, oc1_r, oc0_r, os_r};

  assign stat.keep     = keep;
  assign stat.few      = nval < PUW'(3);
  assign stat.mul_busy = mbusy_r;
  assign stat.div_busy = dbusy_r;
  assign stat.cor_busy = cbusy_r;
  assign stat.det_zero = det_r == '0;
  assign stat.out_free = !ov_r || out_tready;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_POINTS + 1))
    else $error("point count beyond saturation");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (os_r <= ST_DROP))
    else $error("undefined status code on result item");

  a_no_fit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (os_r == ST_FEW || os_r == ST_SING)) |->
      (oc0_r == '0 && oc1_r == '0 && oc2_r == '0 && oyaw_r == '0))
    else $error("coefficients not cleared on failed fit");

  a_one_engine: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mbusy_r, dbusy_r, cbusy_r}) <= 1)
    else $error("arithmetic units overlap");
`endif

endmodule

// ===== rtl/core/quadratic_least_squares_fit.sv =====
// A kept point is accepted and then updates the power sums of y^2, y^3, y^4, xy and
// xy^2 in turn on the shared 25x25 multiplier, with in_tready low; a dropped point is
// only accepted. The final point then starts the fit, unless fewer than three points
// were kept: four 3x3 determinants of six terms each, 48 products on a bit-serial
// shift-add multiplier, three bit-serial divisions and a CORDIC before the result item,
// the divisions and CORDIC only for a nonzero determinant. A finished item waits in the
// output register while the next set of points is taken in.
// Top level of the quadratic lane fit; depends on qlsf_pkg, qlsf_ctrl and qlsf_dp.
module quadratic_least_squares_fit
  import qlsf_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // x[11:0], y[23:12]
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata   // status[2:0], c0[34:3], c1[66:35], c2[98:67],
                                        // cte[130:99], heading_err[148:131],
                                        // points_used[157:149], zero[159:158]
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qlsf_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_x       (signed'(in_tdata[XW-1:0])),
    .in_y       (signed'(in_tdata[2*XW-1:XW])),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
